// ===== rtl/core/scfe_pkg.sv =====
// shared types and constants for the second-chance frame evictor
// no dependencies
package scfe_pkg;

    localparam int FRAMES  = 64;
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int COUNT_W = FRAME_W + 1;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         kind_t;
    typedef logic [1:0]         status_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_TOUCH  = 2'd1;
    localparam kind_t KIND_EVICT  = 2'd2;
    localparam kind_t KIND_REMOVE = 2'd3;

    localparam status_t STAT_DONE = 2'd0;
    localparam status_t STAT_NONE = 2'd1;
    localparam status_t STAT_DUP  = 2'd2;

    // one ring operation per cycle from the sequencer
    typedef struct packed {
        logic   push;
        logic   pop;
        frame_t push_frame;
    } ring_cmd_t;

endpackage

// ===== rtl/core/scfe_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module scfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/scfe_ring.sv =====
// circular queue of frame numbers: head and count pointers over a ram
// depends on scfe_pkg and scfe_ram
module scfe_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  scfe_pkg::ring_cmd_t cmd,
    output scfe_pkg::frame_t   head_frame,
    output scfe_pkg::count_t   count,
    output logic               empty
);
    import scfe_pkg::*;

    frame_t head_reg;
    frame_t head_next;
    count_t count_reg;
    count_t count_next;
    frame_t tail_addr;

    // tail slot wraps naturally in the frame-wide index
    assign tail_addr = head_reg + count_reg[FRAME_W-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next = head_reg + frame_t'(1);
        end
        if (cmd.push && !cmd.pop)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (cmd.pop && !cmd.push)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    scfe_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_addr),
        .wdata (cmd.push_frame),
        .re    (cmd.pop),
        .raddr (head_reg),
        .rdata (head_frame)
    );

    assign count = count_reg;
    assign empty = (count_reg == '0);

endmodule

// ===== rtl/core/second_chance_frame_evictor.sv =====
// second-chance (clock) frame evictor: top level with request sequencer and flags
// depends on scfe_pkg, scfe_ring and scfe_ram
//
// usage
//   a request (kind, frame) is taken at a rising edge where start is high and
//   busy is low. every request gives exactly one result: done pulses high for
//   one cycle with victim and status valid in that cycle. the receiver cannot
//   stall, so the result must be captured in that cycle.
//   kinds: add pushes a frame at the ring tail, touch sets its accessed flag,
//   remove drops residency (its ring entry is discarded when later popped),
//   evict walks the ring from the head giving accessed frames a second chance.
// request flow
//   add, touch and remove: result in the cycle after the request; busy stays low,
//   so a new request can be given in the cycle the result shows.
//   evict: each ring entry popped takes a pop step and then an evaluation of the
//   frame, as the single ram read port gives registered data; when the ring runs
//   empty, a last pop step gives status none. one pass clears every accessed flag,
//   so a walk pops at most occupancy + 1 entries. busy is high for the whole walk.
// reset
//   rst_n low clears the ring pointers and all per-frame flags; the ring ram
//   holds no reset value and is only read inside the occupied window.
module second_chance_frame_evictor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scfe_pkg::kind_t   kind,
    input  scfe_pkg::frame_t  frame,
    output logic              done,
    output scfe_pkg::frame_t  victim,
    output scfe_pkg::status_t status
);
    import scfe_pkg::*;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // per-frame flags held in flops, cleared at reset
    logic [FRAMES-1:0] resident_reg;
    logic [FRAMES-1:0] resident_next;
    logic [FRAMES-1:0] in_ring_reg;
    logic [FRAMES-1:0] in_ring_next;
    logic [FRAMES-1:0] accessed_reg;
    logic [FRAMES-1:0] accessed_next;

    // result registers
    logic    done_reg;
    logic    done_next;
    frame_t  victim_reg;
    frame_t  victim_next;
    status_t status_reg;
    status_t status_next;

    ring_cmd_t ring_cmd;
    frame_t    head_frame;
    count_t    ring_count;
    logic      ring_empty;
    logic      accept;

    assign accept = start && (state_reg == S_IDLE);

    scfe_ring u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ring_cmd),
        .head_frame (head_frame),
        .count      (ring_count),
        .empty      (ring_empty)
    );

    always_comb
    begin
        state_next    = state_reg;
        resident_next = resident_reg;
        in_ring_next  = in_ring_reg;
        accessed_next = accessed_reg;
        done_next     = 1'b0;
        victim_next   = victim_reg;
        status_next   = status_reg;
        ring_cmd      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    victim_next = '0;
                    status_next = STAT_DONE;
                    case (kind)
                        KIND_ADD:
                        begin
                            done_next = 1'b1;
                            if (resident_reg[frame])
                            begin
                                status_next = STAT_DUP;
                            end
                            else
                            begin
                                resident_next[frame] = 1'b1;
                                accessed_next[frame] = 1'b0;
                                // a removed frame still in the ring keeps its slot
                                if (!in_ring_reg[frame])
                                begin
                                    in_ring_next[frame] = 1'b1;
                                    ring_cmd.push       = 1'b1;
                                    ring_cmd.push_frame = frame;
                                end
                            end
                        end
                        KIND_TOUCH:
                        begin
                            done_next = 1'b1;
                            if (resident_reg[frame])
                            begin
                                accessed_next[frame] = 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            done_next            = 1'b1;
                            resident_next[frame] = 1'b0;
                            accessed_next[frame] = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_POP;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (ring_empty)
                begin
                    // nothing resident left to evict
                    done_next   = 1'b1;
                    victim_next = '0;
                    status_next = STAT_NONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ring_cmd.pop = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!resident_reg[head_frame])
                begin
                    // stale entry of a removed frame: drop it
                    in_ring_next[head_frame] = 1'b0;
                    state_next               = S_POP;
                end
                else if (accessed_reg[head_frame])
                begin
                    // second chance: clear flag and requeue at the tail
                    accessed_next[head_frame] = 1'b0;
                    ring_cmd.push             = 1'b1;
                    ring_cmd.push_frame       = head_frame;
                    state_next                = S_POP;
                end
                else
                begin
                    in_ring_next[head_frame]  = 1'b0;
                    resident_next[head_frame] = 1'b0;
                    done_next                 = 1'b1;
                    victim_next               = head_frame;
                    status_next               = STAT_DONE;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            resident_reg <= '0;
            in_ring_reg  <= '0;
            accessed_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            resident_reg <= resident_next;
            in_ring_reg  <= in_ring_next;
            accessed_reg <= accessed_next;
            done_reg     <= done_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        status_reg <= status_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign victim = victim_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    // a result is only given once the walk has ended
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // between requests every ring entry belongs to exactly one in-ring frame
    a_ring_count : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(in_ring_reg) == int'(ring_count)))
        else $error("ring occupancy does not match in-ring flags");

    // a resident frame always has a ring entry
    a_resident_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
        ((resident_reg & ~in_ring_reg) == '0))
        else $error("resident frame missing from ring");

    // an accessed flag is never left on a frame that is not resident
    a_accessed_resident : assert property (@(posedge clk) disable iff (!rst_n)
        ((accessed_reg & ~resident_reg) == '0))
        else $error("accessed flag on non-resident frame");
`endif

endmodule
